FILE: src/hds_pkg.sv
// Shared types, constants and saturation helpers for the heat diffusion stencil.
package hds_pkg;

	localparam int TEMP_W     = 24;
	localparam int SUM_W      = 48;
	localparam int SAT_W      = 48;
	localparam int FRAC_W     = 16;
	localparam int COOL_W     = 10;
	localparam int DIM_CALC_W = 13;
	localparam int WIN_COLS   = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	localparam int COLS_RST       = 1024;
	localparam int ROWS_RST       = 1024;
	localparam int COOL_FIRST_RST = 450;
	localparam int COOL_END_RST   = 573;

	// Q0.16 factors: 0.05, 0.01, 0.10
	localparam int K_CHIP_W = 13;
	localparam int K_COOL_W = 11;
	localparam int K_DIFF_W = 14;
	localparam logic signed [K_CHIP_W-1:0] K_CHIP = 13'sd3277;
	localparam logic signed [K_COOL_W-1:0] K_COOL = 11'sd655;
	localparam logic signed [K_DIFF_W-1:0] K_DIFF = 14'sd6554;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXT_TEMP   = 3'd0,
		REG_COLS       = 3'd1,
		REG_ROWS       = 3'd2,
		REG_COOL_FIRST = 3'd3,
		REG_COOL_END   = 3'd4
	} cfg_reg_t;

	// one column of the 3x3 window
	typedef struct packed {
		logic signed [TEMP_W-1:0] top;
		logic signed [TEMP_W-1:0] mid;
		logic signed [TEMP_W-1:0] bot;
	} col_t;

	// one line buffer word: rows r-2 and r-1 at the same column
	typedef struct packed {
		logic signed [TEMP_W-1:0] upper;
		logic signed [TEMP_W-1:0] middle;
	} lb_word_t;

	function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [SAT_W-1:0] x);
		if ((&x[SAT_W-1:TEMP_W-1]) || !(|x[SAT_W-1:TEMP_W-1])) begin
			return x[TEMP_W-1:0];
		end
		return x[SAT_W-1] ? {1'b1, {(TEMP_W-1){1'b0}}} : {1'b0, {(TEMP_W-1){1'b1}}};
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
		if (x[SUM_W] == x[SUM_W-1]) begin
			return x[SUM_W-1:0];
		end
		return x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
	endfunction

endpackage

FILE: src/hds_if.sv
// Valid/ready stream interfaces for grid cells in and diffused results out.
interface hds_cell_if;
	import hds_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] cell_temp;
	logic signed [TEMP_W-1:0] chip_temp;

	modport source (output valid, output cell_temp, output chip_temp, input ready);
	modport sink (input valid, input cell_temp, input chip_temp, output ready);
	modport monitor (input valid, input ready, input cell_temp, input chip_temp);
endinterface

interface hds_result_if;
	import hds_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] new_temp;
	logic signed [SUM_W-1:0]  frame_sum;
	logic                     frame_done;

	modport source (output valid, output new_temp, output frame_sum, output frame_done,
		input ready);
	modport sink (input valid, input new_temp, input frame_sum, input frame_done,
		output ready);
	modport monitor (input valid, input ready, input new_temp, input frame_sum,
		input frame_done);
endinterface

FILE: src/heat_diffusion_stencil.sv
// Top level: raster heat diffusion stencil with chip heating and air cooling.
//
// cells:   valid/ready stream of grid cells in raster order, column 0 first,
//          each word carrying cell_temp and chip_temp (signed Q16.8).
// results: valid/ready stream, one word per interior cell (r-1,c-1) once
//          cell (r,c) with r>=2, c>=2 has been taken; border cells give none.
//          frame_sum is the saturated running sum, frame_done marks the
//          last interior cell of the frame.
// cfg:     write port (cfg_we, cfg_index, cfg_wdata); write only when idle.
// Throughput: one cell per cycle unless stalled, set by the single read
// and single write port of the line buffer memory, both used once per cell.
// Pipeline: the completing cell of a result passes through 8 pipeline
// stages, then the output register.
// Reset: registers return to defaults, then the line buffer is zeroed one
// column per cycle, all MAX_COLS columns, with cells.ready low.
// Stall: a held result sits in the output register; the stages behind it
// keep filling their empty slots, and cells.ready drops only once all are
// full.
module heat_diffusion_stencil #(
	parameter int MAX_COLS = hds_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = hds_pkg::MAX_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hds_cell_if.sink                         cells,
	hds_result_if.source                     results,
	input  logic                             cfg_we,
	input  logic [hds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import hds_pkg::*;

	localparam int CW   = $clog2(MAX_COLS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CDW  = $clog2(MAX_COLS + 1);
	localparam int RDW  = $clog2(MAX_ROWS + 1);
	localparam int CX   = ((CDW > COOL_W) ? CDW : COOL_W) + 1;
	localparam int RX   = RDW + 1;
	localparam int NSTG = 8;
	localparam int HDW  = TEMP_W + 1;
	localparam int HPW  = HDW + K_CHIP_W;
	localparam int CPW  = HDW + K_COOL_W;
	localparam int S3W  = TEMP_W + 2;
	localparam int PW   = TEMP_W + 1;
	localparam int DW   = TEMP_W + 5;
	localparam int DPW  = DW + K_DIFF_W;
	localparam int COLS_RST_V = (MAX_COLS < COLS_RST) ? MAX_COLS : COLS_RST;
	localparam int ROWS_RST_V = (MAX_ROWS < ROWS_RST) ? MAX_ROWS : ROWS_RST;

	typedef struct packed {
		logic emit;
		logic done;
		logic fend;
	} item_tag_t;

	function automatic logic [DIM_CALC_W-1:0] clamp_dim(input logic [10:0] v,
		input logic [DIM_CALC_W-1:0] maxv);
		if (v < 11'd3) begin
			return DIM_CALC_W'(3);
		end
		if (DIM_CALC_W'(v) > maxv) begin
			return maxv;
		end
		return DIM_CALC_W'(v);
	endfunction

	// configuration
	logic signed [TEMP_W-1:0] ext_q;
	logic [CDW-1:0]           cols_q;
	logic [RDW-1:0]           rows_q;
	logic [COOL_W-1:0]        cool_first_q;
	logic [COOL_W-1:0]        cool_end_q;

	// position of the next cell
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// handshake and pipeline flow
	logic             acc;
	logic             lb_busy;
	logic [NSTG:1]    vld_q;
	logic [NSTG:1]    mv;
	logic [NSTG+1:1]  free;
	logic             out_vld_q;

	// classification of the incoming cell
	logic interior, cool_band, emit, done, last_col, last_row;

	// stage registers
	logic signed [TEMP_W-1:0] u_s1, chip_s1, u_s2, u1_s3, u1_s4, bot_s5, ctr_s5;
	logic signed [TEMP_W-1:0] ctr_s6, ctr_s7, t_s8;
	logic                     int_s1, cool_s1, cool_s2, cool_s3;
	logic [CW-1:0]            col_s1, col_s2, col_s3, col_s4;
	item_tag_t                tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic signed [HPW-1:0]    hp_s2;
	logic signed [CPW-1:0]    cp_s4;
	logic signed [S3W-1:0]    sfar_s5, snear_s5;
	logic signed [PW-1:0]     stm_s5;
	logic signed [DW-1:0]     d_s6;
	logic signed [DPW-1:0]    dp_s7;

	// output register and frame sum
	logic signed [TEMP_W-1:0] new_temp_q;
	logic signed [SUM_W-1:0]  frame_sum_q;
	logic                     frame_done_q;
	logic signed [SUM_W-1:0]  acc_q;

	// combinational datapath
	logic signed [HDW-1:0]    hdiff, cdiff;
	logic signed [HPW-1:0]    hprod;
	logic signed [CPW-1:0]    cprod;
	logic signed [SAT_W-1:0]  heat_sum, cool_sum, diff_sum;
	logic signed [TEMP_W-1:0] u1, bot, t_new;
	logic signed [DW-1:0]     dsum;
	logic signed [DPW-1:0]    dprod;
	logic signed [SUM_W-1:0]  acc_next;

	// line buffer and window chain
	lb_word_t              lb_rd, lb_wr;
	col_t                  new_col;
	col_t                  win_d [WIN_COLS];
	col_t                  win_q [WIN_COLS];
	logic signed [S3W-1:0] win_sum [WIN_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q        <= '0;
			cols_q       <= CDW'(COLS_RST_V);
			rows_q       <= RDW'(ROWS_RST_V);
			cool_first_q <= COOL_W'(COOL_FIRST_RST);
			cool_end_q   <= COOL_W'(COOL_END_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXT_TEMP:   ext_q <= cfg_wdata[TEMP_W-1:0];
				REG_COLS:       cols_q <= CDW'(clamp_dim(cfg_wdata[10:0],
					DIM_CALC_W'(MAX_COLS)));
				REG_ROWS:       rows_q <= RDW'(clamp_dim(cfg_wdata[10:0],
					DIM_CALC_W'(MAX_ROWS)));
				REG_COOL_FIRST: cool_first_q <= cfg_wdata[COOL_W-1:0];
				REG_COOL_END:   cool_end_q <= cfg_wdata[COOL_W-1:0];
				default: ;
			endcase
		end
	end

	// position checks, widened so the +1/+2 never wrap
	assign interior  = (row_q != '0) && ((RX'(row_q) + RX'(2)) <= RX'(rows_q))
		&& (col_q != '0) && ((CX'(col_q) + CX'(2)) <= CX'(cols_q));
	assign cool_band = (CX'(col_q) >= CX'(cool_first_q)) && (CX'(col_q) < CX'(cool_end_q));
	assign emit      = (RX'(row_q) >= RX'(2)) && (CX'(col_q) >= CX'(2))
		&& (RX'(row_q) < RX'(rows_q)) && (CX'(col_q) < CX'(cols_q));
	assign done      = ((RX'(row_q) + RX'(1)) == RX'(rows_q))
		&& ((CX'(col_q) + CX'(1)) == CX'(cols_q));
	assign last_col  = (CX'(col_q) + CX'(1)) >= CX'(cols_q);
	assign last_row  = (RX'(row_q) + RX'(1)) >= RX'(rows_q);

	// flow control: a stage moves on when the next one is empty or moving
	always_comb begin
		free[NSTG+1] = !out_vld_q || results.ready;
		for (int k = NSTG; k >= 1; k--) begin
			mv[k]   = vld_q[k] && free[k+1];
			free[k] = !vld_q[k] || free[k+1];
		end
	end

	assign cells.ready = free[1] && !lb_busy;
	assign acc         = cells.valid && cells.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (acc) begin
				vld_q[1] <= 1'b1;
			end else if (mv[1]) begin
				vld_q[1] <= 1'b0;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (mv[k-1]) begin
					vld_q[k] <= 1'b1;
				end else if (mv[k]) begin
					vld_q[k] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// chip heating product, cooling product, diffusion product
	assign hdiff    = HDW'(chip_s1) - HDW'(u_s1);
	assign hprod    = hdiff * K_CHIP;
	assign heat_sum = SAT_W'(u_s2) + SAT_W'(hp_s2 >>> FRAC_W);
	assign u1       = sat_temp(heat_sum);
	assign cdiff    = HDW'(u1_s3) - HDW'(ext_q);
	assign cprod    = cdiff * K_COOL;
	assign cool_sum = SAT_W'(u1_s4) - SAT_W'(cp_s4 >>> FRAC_W);
	assign bot      = sat_temp(cool_sum);
	// sum of 8 neighbours minus 8*center, with the center folded out of the near column
	assign dsum     = DW'(sfar_s5) + DW'(snear_s5) + DW'(stm_s5) + DW'(bot_s5)
		- (DW'(ctr_s5) <<< 3) - DW'(ctr_s5);
	assign dprod    = d_s6 * K_DIFF;
	assign diff_sum = SAT_W'(ctr_s7) + SAT_W'(dp_s7 >>> FRAC_W);
	assign t_new    = sat_temp(diff_sum);
	assign acc_next = sat_sum((SUM_W+1)'(acc_q) + (SUM_W+1)'(t_s8));

	always_ff @(posedge clk) begin
		if (acc) begin
			u_s1    <= cells.cell_temp;
			chip_s1 <= cells.chip_temp;
			int_s1  <= interior;
			cool_s1 <= interior && cool_band;
			col_s1  <= col_q;
			tag_s1  <= '{emit: emit, done: done, fend: last_col && last_row};
		end
		if (mv[1]) begin
			hp_s2   <= (int_s1 && (chip_s1 > u_s1)) ? hprod : '0;
			u_s2    <= u_s1;
			cool_s2 <= cool_s1;
			col_s2  <= col_s1;
			tag_s2  <= tag_s1;
		end
		if (mv[2]) begin
			u1_s3   <= u1;
			cool_s3 <= cool_s2;
			col_s3  <= col_s2;
			tag_s3  <= tag_s2;
		end
		if (mv[3]) begin
			cp_s4  <= cool_s3 ? cprod : '0;
			u1_s4  <= u1_s3;
			col_s4 <= col_s3;
			tag_s4 <= tag_s3;
		end
		if (mv[4]) begin
			sfar_s5  <= win_sum[0];
			snear_s5 <= win_sum[WIN_COLS-1];
			ctr_s5   <= win_q[WIN_COLS-1].mid;
			stm_s5   <= PW'($signed(lb_rd.upper)) + PW'($signed(lb_rd.middle));
			bot_s5   <= bot;
			tag_s5   <= tag_s4;
		end
		if (mv[5]) begin
			d_s6   <= dsum;
			ctr_s6 <= ctr_s5;
			tag_s6 <= tag_s5;
		end
		if (mv[6]) begin
			dp_s7  <= dprod;
			ctr_s7 <= ctr_s6;
			tag_s7 <= tag_s6;
		end
		if (mv[7]) begin
			t_s8   <= t_new;
			tag_s8 <= tag_s7;
		end
		if (mv[NSTG] && tag_s8.emit) begin
			new_temp_q   <= t_s8;
			frame_sum_q  <= acc_next;
			frame_done_q <= tag_s8.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			acc_q     <= '0;
		end else begin
			if (mv[NSTG]) begin
				out_vld_q <= tag_s8.emit;
				if (tag_s8.fend) begin
					acc_q <= '0;
				end else if (tag_s8.emit) begin
					acc_q <= acc_next;
				end
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// line buffer: read as the cell enters stage 4, write back as it leaves
	assign lb_wr = '{upper: lb_rd.middle, middle: bot};

	hds_line_buf #(
		.DEPTH (MAX_COLS)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mv[3]),
		.rd_addr (col_s3),
		.rd_data (lb_rd),
		.wr_en   (mv[4]),
		.wr_addr (col_s4),
		.wr_data (lb_wr),
		.busy    (lb_busy)
	);

	// window chain: entry 0 holds column c-2, the last entry column c-1
	assign new_col = '{top: lb_rd.upper, mid: lb_rd.middle, bot: bot};

	for (genvar i = 0; i < WIN_COLS; i++) begin : g_win
		if (i == WIN_COLS - 1) begin : g_head
			assign win_d[i] = new_col;
		end else begin : g_body
			assign win_d[i] = win_q[i+1];
		end

		hds_col_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (mv[4]),
			.d      (win_d[i]),
			.q      (win_q[i]),
			.sum3   (win_sum[i])
		);
	end

	assign results.valid      = out_vld_q;
	assign results.new_temp   = new_temp_q;
	assign results.frame_sum  = frame_sum_q;
	assign results.frame_done = frame_done_q;

endmodule

FILE: src/hds_col_cell.sv
// One window column cell: holds a column triple and hands it down the chain.
module hds_col_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             shift,
	input  hds_pkg::col_t                    d,
	output hds_pkg::col_t                    q,
	output logic signed [hds_pkg::TEMP_W+1:0] sum3
);
	import hds_pkg::*;

	localparam int S3W = TEMP_W + 2;

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= d;
		end
	end

	assign q    = col_q;
	assign sum3 = S3W'($signed(col_q.top)) + S3W'($signed(col_q.mid))
		+ S3W'($signed(col_q.bot));

endmodule

FILE: src/hds_line_buf.sv
// Two-row line buffer memory with a zeroing sweep after reset.
module hds_line_buf #(
	parameter int DEPTH = hds_pkg::MAX_COLS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output hds_pkg::lb_word_t        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  hds_pkg::lb_word_t        wr_data,
	output logic                     busy
);
	import hds_pkg::*;

	localparam int AW = $clog2(DEPTH);

	lb_word_t          line_mem [DEPTH];
	lb_word_t          rd_q;
	logic              clr_busy_q;
	logic [AW-1:0]     clr_addr_q;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	lb_word_t          mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign mem_we    = clr_busy_q || wr_en;
	assign mem_addr  = clr_busy_q ? clr_addr_q : wr_addr;
	assign mem_wdata = clr_busy_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= line_mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign busy    = clr_busy_q;

endmodule

FILE: src/hds_checker.sv
// Port-level checks for the heat diffusion stencil, bound to the top level.
module hds_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cells_valid,
	input logic                               cells_ready,
	input logic                               results_valid,
	input logic                               results_ready,
	input logic signed [hds_pkg::TEMP_W-1:0]  new_temp,
	input logic signed [hds_pkg::SUM_W-1:0]   frame_sum,
	input logic                               frame_done
);
	import hds_pkg::*;

	logic                    out_acc;
	logic                    restart_q;
	logic signed [SUM_W-1:0] prev_sum_q;

	assign out_acc = results_valid && results_ready;

	// the first word after reset or after a frame_done word starts a new sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q  <= 1'b1;
			prev_sum_q <= '0;
		end else if (out_acc) begin
			restart_q  <= frame_done;
			prev_sum_q <= frame_sum;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && !results_ready |=> results_valid
		&& $stable(new_temp) && $stable(frame_sum) && $stable(frame_done))
		else $error("result word changed while stalled");

	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !cells_ready)
		else $error("cells taken before line buffer clear");

	a_sum_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && restart_q |-> frame_sum == SUM_W'(new_temp))
		else $error("frame sum did not restart");

	a_sum_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !restart_q |->
		(frame_sum == sat_sum((SUM_W+1)'(prev_sum_q) + (SUM_W+1)'(new_temp)))
		|| (frame_sum == SUM_W'(new_temp)))
		else $error("frame sum does not follow previous word");

endmodule

bind heat_diffusion_stencil hds_checker u_hds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cells_valid   (cells.valid),
	.cells_ready   (cells.ready),
	.results_valid (results.valid),
	.results_ready (results.ready),
	.new_temp      (results.new_temp),
	.frame_sum     (results.frame_sum),
	.frame_done    (results.frame_done)
);
